/* rtl/stt_pkg.sv */
// ============================================================================
// stt_pkg
// Shared types and constants for the software timer table.
// ============================================================================
package stt_pkg;

    localparam int unsigned NUM_TIMERS_DEF = 16;   // default table depth
    localparam int unsigned MAX_FIRE       = 16;   // fired results per tick, at most
    localparam int unsigned FIRE_CNT_W     = 5;    // holds 0..MAX_FIRE

    // Operation codes; code 3 is unused and ignored.
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    // Result kinds.
    localparam logic KIND_DELETE = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  timer_id;
        logic [31:0] expiry_time;
        logic        interval_flag;
        logic [11:0] elapsed_periods;
    } t_item;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] result_timer;
        logic       was_armed;
        logic       last_of_run;
    } t_res;

endpackage

/* rtl/software_timer_table_unit.sv */
// ============================================================================
// software_timer_table_unit
// Table of one-shot software timers with a 32-bit tick count advanced by flagged ticks.
// ============================================================================
// Add: no result. Delete: result registered in the cycle after acceptance.
// Tick (flag set): scans the table one slot per cycle through the expiry
// memory's read port, slower while the result consumer stalls; input is held
// off until the scan ends. Ticks without the flag and unused codes change nothing.
// Reset (synchronous, active low) clears the tick count, all armed bits and
// the control state; the expiry memory is not cleared.
// ============================================================================
module software_timer_table_unit #(
    parameter int unsigned NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    output logic          o_item_ready,
    input  stt_pkg::t_item i_item,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output stt_pkg::t_res o_res
);
    import stt_pkg::*;

    localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    // wide enough for both a timer_id and a slot index, plus headroom for the depth
    localparam int unsigned CmpW = ((IdxW > 4) ? IdxW : 4) + 1;
    localparam logic [IdxW:0]       SlotsEnd = (IdxW + 1)'(NUM_TIMERS);
    localparam logic [CmpW-1:0]     IdLimit  = CmpW'(NUM_TIMERS);
    localparam logic [FIRE_CNT_W-1:0] FireCap = FIRE_CNT_W'(MAX_FIRE);

    // ---------------------------------------------------------------- state
    t_state                r_state,     n_state;
    logic [NUM_TIMERS-1:0] r_armed,     n_armed;      // slot_armed, in flops
    logic [31:0]           r_tick,      n_tick;

    // scan pipeline: r_idx issues the read, r_cmp_* compares the returned data
    logic [IdxW:0]         r_idx,       n_idx;
    logic                  r_cmp_valid, n_cmp_valid;
    logic [IdxW-1:0]       r_cmp_idx,   n_cmp_idx;
    logic [FIRE_CNT_W-1:0] r_fire_cnt,  n_fire_cnt;

    // one fired slot is held back until we know whether it is the last one
    logic                  r_pend_valid, n_pend_valid;
    logic [IdxW-1:0]       r_pend_slot,  n_pend_slot;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out,       n_out;

    // expiry memory, registered read
    logic [31:0]           r_mem [NUM_TIMERS];
    logic [31:0]           r_rd_data;
    logic                  mem_we;
    logic                  rd_en;

    logic                  item_acc;
    logic                  out_free;
    logic [CmpW-1:0]       id_ext;
    logic                  id_in_range;
    logic [IdxW-1:0]       id_slot;
    logic [CmpW-1:0]       pend_ext;
    logic                  scan_hit;
    logic                  stall;

    assign out_free     = !r_out_valid || i_res_ready;
    assign o_item_ready = (r_state == S_IDLE) && out_free;
    assign item_acc     = i_item_valid && o_item_ready;
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

    // timer_id may be narrower or wider than the slot index
    assign id_ext      = CmpW'(i_item.timer_id);
    assign id_in_range = id_ext < IdLimit;
    assign id_slot     = id_ext[IdxW-1:0];
    assign pend_ext    = CmpW'(r_pend_slot);

    // --------------------------------------------------- next state / outputs
    always_comb begin
        n_state      = r_state;
        n_armed      = r_armed;
        n_tick       = r_tick;
        n_idx        = r_idx;
        n_cmp_valid  = r_cmp_valid;
        n_cmp_idx    = r_cmp_idx;
        n_fire_cnt   = r_fire_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out        = r_out;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        scan_hit     = 1'b0;
        stall        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    case (i_item.operation)
                        OP_ADD: begin
                            // re-adding an armed slot just overwrites its expiry
                            if (id_in_range) begin
                                mem_we           = 1'b1;
                                n_armed[id_slot] = 1'b1;
                            end
                        end
                        OP_DEL: begin
                            n_out_valid         = 1'b1;
                            n_out.result_kind   = KIND_DELETE;
                            n_out.result_timer  = i_item.timer_id;
                            n_out.was_armed     = id_in_range && r_armed[id_slot];
                            n_out.last_of_run   = 1'b1;
                            if (id_in_range) begin
                                n_armed[id_slot] = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            if (i_item.interval_flag) begin
                                n_tick       = r_tick + 32'(i_item.elapsed_periods);
                                n_state      = S_SCAN;
                                n_idx        = '0;
                                n_cmp_valid  = 1'b0;
                                n_fire_cnt   = '0;
                                n_pend_valid = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                scan_hit = r_cmp_valid && r_armed[r_cmp_idx] &&
                           (r_rd_data <= r_tick) && (r_fire_cnt < FireCap);
                // a new hit must push the held one out; wait if output is full
                stall    = scan_hit && r_pend_valid && !out_free;

                if (!stall) begin
                    if (scan_hit) begin
                        n_armed[r_cmp_idx] = 1'b0;
                        n_fire_cnt         = r_fire_cnt + 1'b1;
                        if (r_pend_valid) begin
                            n_out_valid        = 1'b1;
                            n_out.result_kind  = KIND_FIRED;
                            n_out.result_timer = pend_ext[3:0];
                            n_out.was_armed    = 1'b1;
                            n_out.last_of_run  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_cmp_idx;
                    end

                    if (r_idx < SlotsEnd) begin
                        rd_en       = 1'b1;
                        n_cmp_valid = 1'b1;
                        n_cmp_idx   = r_idx[IdxW-1:0];
                        n_idx       = r_idx + 1'b1;
                    end else begin
                        n_cmp_valid = 1'b0;
                    end

                    // all slots compared: release the held result as the last one
                    if ((r_idx == SlotsEnd) && !r_cmp_valid) begin
                        if (!r_pend_valid) begin
                            n_state = S_IDLE;
                        end else if (out_free) begin
                            n_out_valid        = 1'b1;
                            n_out.result_kind  = KIND_FIRED;
                            n_out.result_timer = pend_ext[3:0];
                            n_out.was_armed    = 1'b1;
                            n_out.last_of_run  = 1'b1;
                            n_pend_valid       = 1'b0;
                            n_state            = S_IDLE;
                        end
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= '0;
            r_tick       <= '0;
            r_idx        <= '0;
            r_cmp_valid  <= 1'b0;
            r_fire_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_armed      <= n_armed;
            r_tick       <= n_tick;
            r_idx        <= n_idx;
            r_cmp_valid  <= n_cmp_valid;
            r_fire_cnt   <= n_fire_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= n_cmp_idx;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

    // expiry memory: writes only in idle, reads only while scanning, so the
    // two never touch the same entry in overlapping cycles
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[id_slot] <= i_item.expiry_time;
        end
    end

    // read data holds while the compare stage is stalled
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[IdxW-1:0]];
        end
    end

endmodule

/* rtl/stt_checker.sv */
// ============================================================================
// stt_checker
// Port-level assertions for the software timer table, bound to the top level.
// ============================================================================
module stt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_item_valid,
    input logic           o_item_ready,
    input stt_pkg::t_item i_item,
    input logic           o_res_valid,
    input logic           i_res_ready,
    input stt_pkg::t_res  o_res
);
    import stt_pkg::*;

    logic item_acc;
    assign item_acc = i_item_valid && o_item_ready;

    // a stalled result transaction holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("result changed while stalled");

    // a delete answers in the next cycle, alone, with its own slot
    a_del_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && (i_item.operation == OP_DEL)) |=>
        (o_res_valid && (o_res.result_kind == KIND_DELETE) && o_res.last_of_run &&
         (o_res.result_timer == $past(i_item.timer_id))))
        else $error("delete answer missing or wrong");

    // a fired slot was armed
    a_fired_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.result_kind == KIND_FIRED)) |-> o_res.was_armed)
        else $error("fired result without armed flag");

    // a flagged tick starts a scan, no new transaction in the next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && (i_item.operation == OP_TICK) && i_item.interval_flag) |=>
        !o_item_ready)
        else $error("input taken during scan");

endmodule

bind software_timer_table_unit stt_checker u_stt_checker (.*);
